@@ design/cth_pkg.sv @@
package cth_pkg;

  // Defaults for the top-level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Fixed-point layout
  localparam int GUARD_BITS  = 6;
  localparam int TABLE_LEN   = 24;
  localparam int Z_W         = 26;
  localparam int GAIN_W      = 20;
  localparam int MAG_XBITS   = 23;
  localparam int ROUND_SHIFT = GAIN_W + GUARD_BITS;
  localparam int PROD_W      = MAG_XBITS + GAIN_W;
  localparam int SPEED_W     = 16;
  localparam int HEADING_W   = 16;
  localparam int HEADING_LIMIT = 23040;

  localparam logic [GAIN_W-1:0]     GAIN_Q20       = GAIN_W'(636751);
  localparam logic signed [Z_W-1:0] QUARTER_TURN_Z = Z_W'(5898240);

  typedef struct packed {
    logic signed [15:0] long_velocity;
    logic signed [15:0] lat_velocity;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0]          speed;
    logic signed [HEADING_W-1:0] heading;
  } out_t;

  // round(atan(2^-i) in degrees * 65536)
  function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      0:       a = Z_W'(2949120);
      1:       a = Z_W'(1740967);
      2:       a = Z_W'(919879);
      3:       a = Z_W'(466945);
      4:       a = Z_W'(234379);
      5:       a = Z_W'(117304);
      6:       a = Z_W'(58666);
      7:       a = Z_W'(29335);
      8:       a = Z_W'(14668);
      9:       a = Z_W'(7334);
      10:      a = Z_W'(3667);
      11:      a = Z_W'(1833);
      12:      a = Z_W'(917);
      13:      a = Z_W'(458);
      14:      a = Z_W'(229);
      15:      a = Z_W'(115);
      16:      a = Z_W'(57);
      17:      a = Z_W'(29);
      18:      a = Z_W'(14);
      19:      a = Z_W'(7);
      20:      a = Z_W'(4);
      21:      a = Z_W'(2);
      22:      a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ design/cth_prerot.sv @@
module cth_prerot #(
  parameter int SAMPLE_BITS = 16,
  parameter int DW          = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  cth_pkg::in_t                    up_data,
  input  logic                            dn_ready,
  output logic                            dn_valid,
  output logic signed [DW-1:0]            x_o,
  output logic signed [DW-1:0]            y_o,
  output logic signed [cth_pkg::Z_W-1:0]  z_o,
  output logic                            zero_o
);
  import cth_pkg::*;

  logic signed [SAMPLE_BITS-1:0] lon_s, lat_s;
  logic signed [DW-1:0] lon_x, lat_x;
  logic signed [DW-1:0] x_nxt, y_nxt;
  logic signed [Z_W-1:0] z_nxt;
  logic zero_nxt;
  logic v_r;
  logic signed [DW-1:0] x_r, y_r;
  logic signed [Z_W-1:0] z_r;
  logic zero_r;

  // Read each component as SAMPLE_BITS wide: low bits if narrower, zero-extended if wider
  if (SAMPLE_BITS <= 16) begin : g_narrow
    assign lon_s = up_data.long_velocity[SAMPLE_BITS-1:0];
    assign lat_s = up_data.lat_velocity[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign lon_s = {{(SAMPLE_BITS-16){1'b0}}, up_data.long_velocity};
    assign lat_s = {{(SAMPLE_BITS-16){1'b0}}, up_data.lat_velocity};
  end

  // Scale up by the guard bits
  assign lon_x = DW'(lon_s) <<< GUARD_BITS;
  assign lat_x = DW'(lat_s) <<< GUARD_BITS;

  // Fold the left half-plane into the right by a quarter turn
  always_comb begin
    zero_nxt = (lon_s == '0) && (lat_s == '0);
    x_nxt    = lon_x;
    y_nxt    = lat_x;
    z_nxt    = '0;
    if (lon_x[DW-1]) begin
      if (!lat_x[DW-1]) begin
        x_nxt = lat_x;
        y_nxt = -lon_x;
        z_nxt = QUARTER_TURN_Z;
      end else begin
        x_nxt = -lat_x;
        y_nxt = lon_x;
        z_nxt = -QUARTER_TURN_Z;
      end
    end
  end

  assign up_ready = !v_r || dn_ready;

  // Advance the valid flag whenever the stage may take a word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // Load the payload only on an accepted word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign dn_valid = v_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign z_o      = z_r;
  assign zero_o   = zero_r;

endmodule

@@ design/cth_iter.sv @@
module cth_iter #(
  parameter int DW  = 25,
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic signed [DW-1:0]            x_i,
  input  logic signed [DW-1:0]            y_i,
  input  logic signed [cth_pkg::Z_W-1:0]  z_i,
  input  logic                            zero_i,
  input  logic                            dn_ready,
  output logic                            dn_valid,
  output logic signed [DW-1:0]            x_o,
  output logic signed [DW-1:0]            y_o,
  output logic signed [cth_pkg::Z_W-1:0]  z_o,
  output logic                            zero_o
);
  import cth_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_q16(IDX);

  logic signed [DW-1:0] xs, ys;
  logic signed [DW-1:0] x_nxt, y_nxt;
  logic signed [Z_W-1:0] z_nxt;
  logic v_r;
  logic signed [DW-1:0] x_r, y_r;
  logic signed [Z_W-1:0] z_r;
  logic zero_r;

  // Arithmetic shift rounds toward minus infinity
  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // Rotate towards the x axis; a zero y counts as positive
  always_comb begin
    if (!y_i[DW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign dn_valid = v_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign z_o      = z_r;
  assign zero_o   = zero_r;

endmodule

@@ design/cth_scale.sv @@
module cth_scale #(
  parameter int DW = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic signed [DW-1:0]            x_i,
  input  logic signed [cth_pkg::Z_W-1:0]  z_i,
  input  logic                            zero_i,
  input  logic                            dn_ready,
  output logic                            dn_valid,
  output cth_pkg::out_t                   dn_data
);
  import cth_pkg::*;

  localparam int XB = DW - 1;
  localparam int HW = Z_W - 9;
  localparam logic signed [HW-1:0] HLIM = HW'(HEADING_LIMIT);
  localparam logic signed [Z_W-1:0] HROUND = Z_W'(256);
  localparam logic [PROD_W:0] MROUND = (PROD_W + 1)'(1) << (ROUND_SHIFT - 1);
  localparam logic [PROD_W:0] SPEED_MAX = (PROD_W + 1)'({SPEED_W{1'b1}});

  logic [MAG_XBITS-1:0] xsat, xc;
  logic [PROD_W-1:0] prod_nxt;
  logic signed [Z_W-1:0] zr;
  logic signed [HW-1:0] hfull;
  logic signed [HEADING_W-1:0] head_nxt;
  logic a_ready, b_ready;
  logic va_r, vb_r;
  logic [PROD_W-1:0] prod_r;
  logic signed [HEADING_W-1:0] head_a_r;
  logic [PROD_W:0] msum;
  logic [PROD_W:0] mshift;
  logic [SPEED_W-1:0] speed_nxt;
  out_t out_r;

  // Clamp x to the range where the scaled magnitude can still fit
  if (XB <= MAG_XBITS) begin : g_small
    assign xsat = MAG_XBITS'(x_i[XB-1:0]);
  end else begin : g_big
    assign xsat = (|x_i[XB-1:MAG_XBITS]) ? '1 : x_i[MAG_XBITS-1:0];
  end
  assign xc = x_i[DW-1] ? '0 : xsat;

  // Gain correction product
  assign prod_nxt = PROD_W'(xc) * PROD_W'(GAIN_Q20);

  // Round the angle to 1/128 degree and clamp to half a turn
  assign zr    = z_i + HROUND;
  assign hfull = zr[Z_W-1:9];
  always_comb begin
    if (zero_i) begin
      head_nxt = '0;
    end else if (hfull > HLIM) begin
      head_nxt = HLIM[HEADING_W-1:0];
    end else if (hfull < -HLIM) begin
      head_nxt = -HLIM[HEADING_W-1:0];
    end else begin
      head_nxt = hfull[HEADING_W-1:0];
    end
  end

  assign up_ready = !va_r || a_ready;
  assign a_ready  = b_ready;
  assign b_ready  = !vb_r || dn_ready;

  // Product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (up_ready) begin
      va_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_r   <= prod_nxt;
      head_a_r <= head_nxt;
    end
  end

  // Round, shift down and saturate the magnitude
  assign msum      = {1'b0, prod_r} + MROUND;
  assign mshift    = msum >> ROUND_SHIFT;
  assign speed_nxt = (mshift > SPEED_MAX) ? '1 : mshift[SPEED_W-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (b_ready) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && va_r) begin
      out_r.speed   <= speed_nxt;
      out_r.heading <= head_a_r;
    end
  end

  assign dn_valid = vb_r;
  assign dn_data  = out_r;

endmodule

@@ design/cartesian_to_polar_heading_unit.sv @@
// Converts one velocity word (signed Q8.8 longitudinal and lateral parts) into
// speed (unsigned Q8.8, saturated at 65535) and heading atan2(lat, long) in
// 1/128 degree, clamped to +/-180 degrees; a zero vector gives heading 0. The
// unit is a fully unrolled CORDIC pipeline and takes a new word every cycle
// while the output is not stalled. Its stages are one quadrant fold stage, one
// stage per CORDIC iteration, a gain-correction multiply stage and an output
// rounding register. Every stage has its own valid bit and takes a word as
// soon as its successor moves, so back-pressure only fills bubbles.
module cartesian_to_polar_heading_unit #(
  parameter int CORDIC_STEPS = cth_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = cth_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cth_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cth_pkg::out_t  out_data
);
  import cth_pkg::*;

  localparam int ITERS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int DW    = SAMPLE_BITS + GUARD_BITS + 3;

  logic                  v_w    [0:ITERS];
  logic                  rdy_w  [0:ITERS];
  logic signed [DW-1:0]  x_w    [0:ITERS];
  logic signed [DW-1:0]  y_w    [0:ITERS];
  logic signed [Z_W-1:0] z_w    [0:ITERS];
  logic                  zero_w [0:ITERS];

  // Quadrant fold
  cth_prerot #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DW          (DW)
  ) u_prerot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_ready (rdy_w[0]),
    .dn_valid (v_w[0]),
    .x_o      (x_w[0]),
    .y_o      (y_w[0]),
    .z_o      (z_w[0]),
    .zero_o   (zero_w[0])
  );

  // One stage per CORDIC iteration
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    cth_iter #(
      .DW  (DW),
      .IDX (i)
    ) u_iter (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v_w[i]),
      .up_ready (rdy_w[i]),
      .x_i      (x_w[i]),
      .y_i      (y_w[i]),
      .z_i      (z_w[i]),
      .zero_i   (zero_w[i]),
      .dn_ready (rdy_w[i+1]),
      .dn_valid (v_w[i+1]),
      .x_o      (x_w[i+1]),
      .y_o      (y_w[i+1]),
      .z_o      (z_w[i+1]),
      .zero_o   (zero_w[i+1])
    );
  end

  // Gain correction, rounding and output register
  cth_scale #(
    .DW (DW)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v_w[ITERS]),
    .up_ready (rdy_w[ITERS]),
    .x_i      (x_w[ITERS]),
    .z_i      (z_w[ITERS]),
    .zero_i   (zero_w[ITERS]),
    .dn_ready (out_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data)
  );

  // An empty output register leaves room all the way back to the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // Heading clamp
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.heading) <= $signed(16'(HEADING_LIMIT)) &&
                   $signed(out_data.heading) >= -$signed(16'(HEADING_LIMIT))))
    else $error("heading outside half a turn");

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

@@ bench/cartesian_to_polar_heading_unit_tb.sv @@
module cartesian_to_polar_heading_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cth_pkg::*;

  localparam int CLOCK_HALF = 4;
  localparam int RESET_CYCLES = 8;
  // Pipeline depth of the unit: fold stage, one per iteration, multiply, output register
  localparam int ITERATIONS = (CORDIC_STEPS_DEF < TABLE_LEN) ? CORDIC_STEPS_DEF : TABLE_LEN;
  localparam int PIPE_DEPTH = ITERATIONS + 3;
  localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH + 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_GAP = 19;
  localparam int MAX_REPORTS = 200;
  localparam longint SPEED_MAX = 65535;

  // atan(2^-i) in degrees, units of 2^-16 degree
  localparam longint ARCTAN_Q16 [0:TABLE_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t polar_q[$];
  int error_count = 0;
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  bit rx_hold_req = 1'b0;

  cartesian_to_polar_heading_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  // Work out speed and heading for one velocity word
  function automatic out_t polar_of(input in_t w);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    longint mag;
    longint hdg;
    out_t r;
    x = longint'($signed(w.long_velocity));
    y = longint'($signed(w.lat_velocity));
    if (x == 0 && y == 0) begin
      return '0;
    end
    x = x <<< GUARD_BITS;
    y = y <<< GUARD_BITS;
    z = 0;
    // fold the left half-plane onto the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(QUARTER_TURN_Z);
      end else begin
        x = -y;
        y = t;
        z = -longint'(QUARTER_TURN_Z);
      end
    end
    // rotate towards the x axis; zero lateral counts as positive
    for (int i = 0; i < ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q16[i];
      end
    end
    if (x < 0) begin
      x = 0;
    end
    mag = (x * longint'(GAIN_Q20) + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (mag > SPEED_MAX) begin
      mag = SPEED_MAX;
    end
    hdg = (z + 256) >>> 9;
    if (hdg > HEADING_LIMIT) begin
      hdg = HEADING_LIMIT;
    end
    if (hdg < -HEADING_LIMIT) begin
      hdg = -HEADING_LIMIT;
    end
    r.speed = SPEED_W'(mag);
    r.heading = HEADING_W'(hdg);
    return r;
  endfunction

  // Offer one word, hold it until taken, then maybe idle for a burst
  task automatic send_word(input logic signed [15:0] lon, input logic signed [15:0] lat);
    in_t w;
    int gap;
    w.long_velocity = lon;
    w.lat_velocity = lat;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    polar_q.push_back(polar_of(w));
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, MAX_GAP);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (polar_q.size() != 0) @(posedge clk);
  endtask

  // Random velocity word: mostly full range, some small, some on axes and diagonals
  task automatic send_random_word();
    logic signed [15:0] lon;
    logic signed [15:0] lat;
    int pick;
    pick = $urandom_range(0, 9);
    lon = 16'($urandom);
    lat = 16'($urandom);
    if (pick < 2) begin
      lon = 16'($signed($urandom_range(0, 1024)) - 512);
      lat = 16'($signed($urandom_range(0, 1024)) - 512);
    end else if (pick == 2) begin
      case ($urandom_range(0, 3))
        0: lat = '0;
        1: lon = '0;
        2: lat = lon;
        default: lat = -lon;
      endcase
    end
    send_word(lon, lat);
  endtask

  task automatic test_directed_extremes();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    // zero vector
    send_word(16'sd0, 16'sd0);
    // axes, including negative longitudinal with zero lateral
    send_word(16'sd32767, 16'sd0);
    send_word(-16'sd32768, 16'sd0);
    send_word(16'sd0, 16'sd32767);
    send_word(16'sd0, -16'sd32768);
    send_word(16'sd1, 16'sd0);
    send_word(-16'sd1, 16'sd0);
    send_word(16'sd0, 16'sd1);
    send_word(16'sd0, -16'sd1);
    send_word(-16'sd256, 16'sd0);
    // corners, largest magnitude
    send_word(16'sd32767, 16'sd32767);
    send_word(-16'sd32768, -16'sd32768);
    send_word(16'sd32767, -16'sd32768);
    send_word(-16'sd32768, 16'sd32767);
    // left half-plane on either side of the axis
    send_word(-16'sd1, 16'sd1);
    send_word(-16'sd1, -16'sd1);
    send_word(-16'sd300, 16'sd5);
    send_word(-16'sd300, -16'sd5);
    // small, diagonal and next to the lateral axis
    send_word(16'sd1, 16'sd1);
    send_word(16'sd256, -16'sd256);
    send_word(-16'sd1, 16'sd32767);
    send_word(-16'sd1, -16'sd32768);
    drain_results();
  endtask

  task automatic test_random_with_idling(input int count);
    for (int n = 0; n < count; n++) begin
      // change idling pattern now and then, leaving quiet stretches
      if (n % 100 == 0) begin
        tx_gaps_on = $urandom_range(0, 2) != 0;
        rx_stalls_on = $urandom_range(0, 2) != 0;
      end
      send_random_word();
    end
  endtask

  task automatic test_backpressure_fill(input int count);
    tx_gaps_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int n = 0; n < count; n++) begin
      send_random_word();
    end
  endtask

  task automatic test_pause_then_resume(input int count);
    drain_results();
    test_random_with_idling(count);
  endtask

  task automatic test_full_rate(input int count);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    for (int n = 0; n < count; n++) begin
      send_random_word();
    end
  endtask

  // Stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_random_with_idling(500);
    test_backpressure_fill(80);
    test_pause_then_resume(320);
    test_full_rate(400);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side ready: random stall bursts, plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, MAX_GAP);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest predicted one
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) begin
        if (polar_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected word speed=%0d heading=%0d", $realtime,
                     out_data.speed, $signed(out_data.heading));
          end
        end else begin
          want = polar_q.pop_front();
          if (out_data.speed !== want.speed) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: speed expected %0d got %0d", $realtime, want.speed,
                       out_data.speed);
            end
          end
          if (out_data.heading !== want.heading) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: heading expected %0d got %0d", $realtime,
                       $signed(want.heading), $signed(out_data.heading));
            end
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
